FILE: src/sqr_pkg.sv
// Shared types and constants for the shift queue with reorder.
package sqr_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MOVE_W     = 8;

  typedef enum logic [1:0] {
    CMD_ENQ     = 2'd0,
    CMD_DEQ     = 2'd1,
    CMD_PROMOTE = 2'd2,
    CMD_DEMOTE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [DATA_WIDTH-1:0] item_data;
    logic [MOVE_W-1:0]     positions;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] removed_data;
    logic [DATA_WIDTH-1:0] head_data;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_empty;
  } out_item_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic                  en;       // accepted and successful
    cmd_t                  op;
    logic [CNT_W-1:0]      count;    // occupancy before the command
    logic [IDX_W-1:0]      tail;     // count - 1
    logic [IDX_W-1:0]      mv;       // clamped move distance
    logic [IDX_W-1:0]      dest;     // promote landing slot
    logic [DATA_WIDTH-1:0] moving;   // item being promoted or demoted
    logic [DATA_WIDTH-1:0] in_data;
  } cell_ctl_t;

endpackage

FILE: src/sqr_cell.sv
// One storage cell of the queue; loads from a neighbour, the input or the moved item.
module sqr_cell (
  input  logic                          clk,
  input  logic [sqr_pkg::IDX_W-1:0]     pos,
  input  sqr_pkg::cell_ctl_t            ctl,
  input  logic [sqr_pkg::DATA_WIDTH-1:0] prev_data,
  input  logic [sqr_pkg::DATA_WIDTH-1:0] next_data,
  output logic [sqr_pkg::DATA_WIDTH-1:0] data
);

  logic [sqr_pkg::DATA_WIDTH-1:0] data_next;
  logic [sqr_pkg::CNT_W-1:0]      pos_w;

  assign pos_w = sqr_pkg::CNT_W'(pos);

  always_comb begin
    data_next = data;
    if (ctl.en) begin
      case (ctl.op)
        sqr_pkg::CMD_ENQ: begin
          if (pos_w == ctl.count) data_next = ctl.in_data;
        end
        sqr_pkg::CMD_DEQ: begin
          data_next = next_data;
        end
        sqr_pkg::CMD_PROMOTE: begin
          if (pos == ctl.dest) data_next = ctl.moving;
          else if (pos > ctl.dest && pos <= ctl.tail) data_next = prev_data;
        end
        sqr_pkg::CMD_DEMOTE: begin
          if (pos < ctl.mv) data_next = next_data;
          else if (pos == ctl.mv) data_next = ctl.moving;
        end
        default: data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: src/shift_queue_with_reorder_unit.sv
// A command is accepted when in_stall is low; its result is valid the next cycle.
// Throughput: one command per cycle while the result side keeps up; every cell
// loads its neighbour, the input word or the moved item in the cycle the command is accepted.
// A result waiting on a stalled output holds off the next command.
// Reset (synchronous, active high) empties the queue and clears the result valid;
// cell contents are left as they are.
module shift_queue_with_reorder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sqr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sqr_pkg::out_item_t out_item
);

  logic [sqr_pkg::DATA_WIDTH-1:0] cell_q [sqr_pkg::DEPTH];
  logic [sqr_pkg::CNT_W-1:0]      count;
  logic [sqr_pkg::CNT_W-1:0]      count_next;
  logic                           ok;
  logic                           ok_next;
  logic [sqr_pkg::DATA_WIDTH-1:0] removed;
  logic [sqr_pkg::DATA_WIDTH-1:0] removed_next;
  logic                           out_valid_next;
  logic                           in_acc;
  logic [sqr_pkg::CNT_W-1:0]      limit;
  logic [sqr_pkg::CNT_W-1:0]      mv_w;
  sqr_pkg::cell_ctl_t             ctl;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Clamp the move to count - 1.
  assign limit = count - sqr_pkg::CNT_W'(1);
  assign mv_w  = (sqr_pkg::MOVE_W'(limit) > in_item.positions)
                 ? sqr_pkg::CNT_W'(in_item.positions) : limit;

  always_comb begin
    ok_next      = 1'b0;
    count_next   = count;
    removed_next = '0;
    case (in_item.command)
      sqr_pkg::CMD_ENQ: begin
        if (count < sqr_pkg::CNT_W'(sqr_pkg::DEPTH)) begin
          ok_next    = 1'b1;
          count_next = count + sqr_pkg::CNT_W'(1);
        end
      end
      sqr_pkg::CMD_DEQ: begin
        if (count != '0) begin
          ok_next      = 1'b1;
          count_next   = count - sqr_pkg::CNT_W'(1);
          removed_next = cell_q[0];
        end
      end
      sqr_pkg::CMD_PROMOTE, sqr_pkg::CMD_DEMOTE: begin
        ok_next = (count >= sqr_pkg::CNT_W'(2));
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_comb begin
    ctl.en      = in_acc && ok_next;
    ctl.op      = in_item.command;
    ctl.count   = count;
    ctl.tail    = limit[sqr_pkg::IDX_W-1:0];
    ctl.mv      = mv_w[sqr_pkg::IDX_W-1:0];
    ctl.dest    = limit[sqr_pkg::IDX_W-1:0] - mv_w[sqr_pkg::IDX_W-1:0];
    ctl.moving  = (in_item.command == sqr_pkg::CMD_PROMOTE)
                  ? cell_q[limit[sqr_pkg::IDX_W-1:0]] : cell_q[0];
    ctl.in_data = in_item.item_data;
  end

  for (genvar i = 0; i < sqr_pkg::DEPTH; i++) begin : g_cell
    logic [sqr_pkg::DATA_WIDTH-1:0] prev_d;
    logic [sqr_pkg::DATA_WIDTH-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == sqr_pkg::DEPTH - 1) begin : g_last
      assign next_d = cell_q[i];
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end
    sqr_cell u_cell (
      .clk       (clk),
      .pos       (sqr_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  assign out_valid_next = in_acc || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (in_acc) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok      <= ok_next;
      removed <= removed_next;
    end
  end

  // Head, occupancy and empty come straight from the state, which holds while stalled.
  always_comb begin
    out_item.ok           = ok;
    out_item.removed_data = removed;
    out_item.head_data    = (count != '0) ? cell_q[0] : '0;
    out_item.occupancy    = count;
    out_item.is_empty     = (count == '0);
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sqr_pkg::CNT_W'(sqr_pkg::DEPTH))
    else $error("occupancy above depth");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_item.command == sqr_pkg::CMD_ENQ &&
     count < sqr_pkg::CNT_W'(sqr_pkg::DEPTH))
    |=> (count == $past(count) + sqr_pkg::CNT_W'(1)) && ok)
    else $error("enqueue did not grow the queue");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(count))
    else $error("occupancy changed without a transaction");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for shift_queue_with_reorder_unit: directed and random commands against a queue model.
module tb_top;
  import sqr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Predicted queue contents, head at index 0, and results still to arrive.
  logic [DATA_WIDTH-1:0] model_q[$];
  out_item_t             results_due[$];

  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_req        = 0;
  int errors          = 0;
  int cmds_sent       = 0;
  int results_checked = 0;
  int refused_full    = 0;
  int refused_empty   = 0;
  int reorders        = 0;

  shift_queue_with_reorder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the queue model and returns the result it should give.
  function automatic out_item_t apply_queue_cmd(in_item_t it);
    out_item_t             res;
    int                    n;
    logic [DATA_WIDTH-1:0] moving;
    res = '0;
    case (it.command)
      CMD_ENQ: begin
        if (model_q.size() < DEPTH) begin
          model_q.push_back(it.item_data);
          res.ok = 1'b1;
        end else begin
          refused_full++;
        end
      end
      CMD_DEQ: begin
        if (model_q.size() > 0) begin
          res.removed_data = model_q.pop_front();
          res.ok = 1'b1;
        end else begin
          refused_empty++;
        end
      end
      default: begin
        if (model_q.size() >= 2) begin
          n = (int'(it.positions) < model_q.size() - 1) ? int'(it.positions)
                                                        : model_q.size() - 1;
          if (it.command == CMD_PROMOTE) begin
            moving = model_q[model_q.size() - 1];
            model_q.delete(model_q.size() - 1);
            model_q.insert(model_q.size() - n, moving);
          end else begin
            moving = model_q.pop_front();
            model_q.insert(n, moving);
          end
          res.ok = 1'b1;
          reorders++;
        end
      end
    endcase
    res.head_data = (model_q.size() > 0) ? model_q[0] : '0;
    res.occupancy = CNT_W'(model_q.size());
    res.is_empty  = (model_q.size() == 0);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_cmd(cmd_t c, logic [DATA_WIDTH-1:0] d, logic [MOVE_W-1:0] p);
    in_item_t it;
    it.command   = c;
    it.item_data = d;
    it.positions = p;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(apply_queue_cmd(it));
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Biased mix so that random runs reach both a full and an empty queue.
  task automatic send_random_cmd(bit fill_bias);
    cmd_t              c;
    int                r;
    logic [MOVE_W-1:0] p;
    r = $urandom_range(99);
    if (r < (fill_bias ? 50 : 20)) c = CMD_ENQ;
    else if (r < 70)               c = CMD_DEQ;
    else if (r < 85)               c = CMD_PROMOTE;
    else                           c = CMD_DEMOTE;
    p = ($urandom_range(3) == 0) ? MOVE_W'($urandom) : MOVE_W'($urandom_range(17));
    send_cmd(c, DATA_WIDTH'($urandom), p);
  endtask

  task automatic test_directed();
    send_cmd(CMD_DEQ, '0, '0);          // dequeue from empty
    send_cmd(CMD_PROMOTE, '1, 8'd1);    // too few items
    send_cmd(CMD_DEMOTE, '1, 8'd1);
    send_cmd(CMD_ENQ, '0, '0);
    send_cmd(CMD_PROMOTE, '0, 8'd3);    // single item
    send_cmd(CMD_DEMOTE, '0, 8'd3);
    send_cmd(CMD_ENQ, '1, '1);
    send_cmd(CMD_ENQ, 32'h5555_AAAA, '0);
    send_cmd(CMD_ENQ, 32'hAAAA_5555, '0);
    send_cmd(CMD_PROMOTE, '0, 8'd0);    // zero positions
    send_cmd(CMD_DEMOTE, '0, 8'd0);
    send_cmd(CMD_PROMOTE, '0, 8'd1);
    send_cmd(CMD_DEMOTE, '0, 8'd1);
    send_cmd(CMD_PROMOTE, '0, 8'd255);  // clamped to the far end
    send_cmd(CMD_DEMOTE, '0, 8'd255);
    send_cmd(CMD_PROMOTE, '0, 8'd3);    // exactly count-1
    send_cmd(CMD_DEMOTE, '0, 8'd4);     // exactly count
    send_cmd(CMD_DEQ, '1, '1);
    send_cmd(CMD_PROMOTE, '0, 8'd2);
    wait_for_results();
  endtask

  task automatic test_full_and_empty();
    while (model_q.size() < DEPTH) send_cmd(CMD_ENQ, DATA_WIDTH'($urandom), '0);
    send_cmd(CMD_ENQ, '1, '0);          // enqueue when full
    send_cmd(CMD_PROMOTE, '0, 8'd255);
    send_cmd(CMD_DEMOTE, '0, 8'd15);
    send_cmd(CMD_ENQ, '0, '0);
    while (model_q.size() > 0) send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_DEQ, '0, '0);
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 60;
    repeat (20) send_random_cmd(1'b1);
    wait_for_results();
  endtask

  task automatic test_random_phase(int idle_pct, int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_cmd(((i / 40) % 2) == 0);
    wait_for_results();
  endtask

  // Receiver stall, driven at the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        out_stall <= 1'b1;
        for (int k = 1; k < hold_req; k++) @(negedge clk);
        hold_req = 0;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result with no transaction outstanding: %p", out_item);
        errors++;
      end else begin
        want = results_due.pop_front();
        bad  = 1'b0;
        if (out_item.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_item.ok);
          bad = 1'b1;
        end
        if (out_item.removed_data !== want.removed_data) begin
          $error("removed_data: expected %h, got %h", want.removed_data,
                 out_item.removed_data);
          bad = 1'b1;
        end
        if (out_item.head_data !== want.head_data) begin
          $error("head_data: expected %h, got %h", want.head_data, out_item.head_data);
          bad = 1'b1;
        end
        if (out_item.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_item.occupancy);
          bad = 1'b1;
        end
        if (out_item.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_item.is_empty);
          bad = 1'b1;
        end
        if (bad) errors++;
        results_checked++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_full_and_empty();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(86, 0);
    test_random_phase(0, 86);
    test_random_phase(22, 22);
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("summary: %0d commands, %0d results checked, %0d reorders", cmds_sent,
             results_checked, reorders);
    $display("summary: %0d enqueues refused on a full queue, %0d dequeues on an empty one",
             refused_full, refused_empty);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sqr_pkg.sv
src/sqr_cell.sv
src/shift_queue_with_reorder_unit.sv
test/tb_top.sv
